// File: hw/rtl/sff_pkg.sv
package sff_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W  = 8;
	localparam int FEAT_W = 18;
	localparam int DIM_W  = 11;
	localparam int CMP_W  = DIM_W + 2;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = 12;
	localparam int LIN_W  = ROW_W + DIM_W;

	localparam logic [ROW_W-1:0] ROW_SAT = {ROW_W{1'b1}};

	localparam int MIN_DIM      = 5;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int RESET_AREA   = RESET_WIDTH * RESET_HEIGHT;
	localparam int RESET_LEAD   = 2 * RESET_WIDTH + 3;

	localparam int BORDER = 2;

	localparam int LANES  = 4;
	localparam int LINE_W = LANES * PIX_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int OUT_DEPTH = 8;
	localparam int OPTR_W    = $clog2(OUT_DEPTH);
	localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

	localparam logic [1:0] RECALC_CYCLES = 2'd2;

	localparam int K_EDGE   = 5;
	localparam int K_NEAR   = 25;
	localparam int K_SIDE   = 50;
	localparam int K_CENTER = 640;
	localparam int K_SCALE  = 1000;

	typedef enum logic {
		OP_PIXEL,
		OP_FLUSH
	} op_t;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT
	} reg_index_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] value;
		logic             emit;
		logic             border;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic [FEAT_W-1:0] feat;
		logic              border;
		logic              last;
	} res_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw, input int top);
		logic [DIM_W-1:0] val;
		val = raw;
		if (int'(raw) < MIN_DIM) begin
			val = DIM_W'(MIN_DIM);
		end else if (int'(raw) > top) begin
			val = DIM_W'(top);
		end
		return val;
	endfunction

endpackage

// File: hw/rtl/sff_ram.sv
module sff_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/sff_front.sv
module sff_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        write_enable,
	input  logic [0:0]                  reg_index,
	input  logic [sff_pkg::DIM_W-1:0]   write_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        operation,
	input  logic [sff_pkg::PIX_W-1:0]   pixel,
	input  logic                        first_of_frame,
	input  logic                        q_full,
	output logic                        push,
	output sff_pkg::cmd_t               push_cmd
);

	localparam int CW = sff_pkg::CMP_W;
	localparam int LW = sff_pkg::LIN_W;

	logic [sff_pkg::DIM_W-1:0] width_raw_q, height_raw_q;
	logic [sff_pkg::DIM_W-1:0] w_q, h_q;
	logic [LW-1:0]             wh_q, lead_q;
	logic [1:0]                recalc_cnt_q;

	logic [sff_pkg::ROW_W-1:0] in_row_q, out_row_q;
	logic [sff_pkg::COL_W-1:0] in_col_q, out_col_q;
	logic [LW-1:0]             lin_in_q, lin_out_q;

	logic                      accept, restart, done, flush, emit;
	logic                      wrap, row_sat, out_wrap;
	logic [sff_pkg::ROW_W-1:0] r_in_row, r_out_row, new_in_row, new_out_row;
	logic [sff_pkg::COL_W-1:0] r_in_col, r_out_col, new_in_col, new_out_col;
	logic [LW-1:0]             r_lin_in, r_lin_out, new_lin_in, new_lin_out;
	logic [CW-1:0]             w_c, h_c, icol_c, orow_c, ocol_c;

	assign in_ready = !q_full && (recalc_cnt_q == 2'd0);
	assign accept   = in_valid && in_ready;

	always_comb begin
		restart   = (operation == sff_pkg::OP_PIXEL) && first_of_frame;
		r_in_row  = restart ? '0 : in_row_q;
		r_in_col  = restart ? '0 : in_col_q;
		r_out_row = restart ? '0 : out_row_q;
		r_out_col = restart ? '0 : out_col_q;
		r_lin_in  = restart ? '0 : lin_in_q;
		r_lin_out = restart ? '0 : lin_out_q;

		w_c    = CW'(w_q);
		h_c    = CW'(h_q);
		icol_c = CW'(r_in_col);
		orow_c = CW'(r_out_row);
		ocol_c = CW'(r_out_col);

		done  = orow_c >= h_c;
		flush = (operation == sff_pkg::OP_FLUSH) || (r_lin_in >= wh_q);

		wrap       = icol_c + CW'(1) >= w_c;
		row_sat    = r_in_row == sff_pkg::ROW_SAT;
		new_in_col = wrap ? '0 : r_in_col + 1'b1;
		new_in_row = (wrap && !row_sat) ? r_in_row + 1'b1 : r_in_row;
		if (wrap) begin
			new_lin_in = r_lin_in - LW'(r_in_col) + (row_sat ? '0 : LW'(w_q));
		end else begin
			new_lin_in = r_lin_in + 1'b1;
		end

		emit = new_lin_in >= r_lin_out + lead_q;

		out_wrap    = ocol_c + CW'(1) >= w_c;
		new_out_col = out_wrap ? '0 : r_out_col + 1'b1;
		new_out_row = out_wrap ? r_out_row + 1'b1 : r_out_row;
		if (out_wrap) begin
			new_lin_out = r_lin_out - LW'(r_out_col) + LW'(w_q);
		end else begin
			new_lin_out = r_lin_out + 1'b1;
		end

		push            = accept && !done;
		push_cmd.col    = r_in_col;
		push_cmd.value  = flush ? '0 : pixel;
		push_cmd.emit   = emit;
		push_cmd.border = (orow_c < CW'(sff_pkg::BORDER))
			|| (orow_c + CW'(sff_pkg::BORDER) >= h_c)
			|| (ocol_c < CW'(sff_pkg::BORDER))
			|| (ocol_c + CW'(sff_pkg::BORDER) >= w_c);
		push_cmd.last   = (orow_c + CW'(1) == h_c) && (ocol_c + CW'(1) == w_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_raw_q  <= sff_pkg::DIM_W'(sff_pkg::RESET_WIDTH);
			height_raw_q <= sff_pkg::DIM_W'(sff_pkg::RESET_HEIGHT);
			recalc_cnt_q <= 2'd0;
		end else if (write_enable) begin
			unique case (reg_index)
				sff_pkg::REG_IMAGE_WIDTH:  width_raw_q  <= write_data;
				sff_pkg::REG_IMAGE_HEIGHT: height_raw_q <= write_data;
				default: ;
			endcase
			recalc_cnt_q <= sff_pkg::RECALC_CYCLES;
		end else if (recalc_cnt_q != 2'd0) begin
			recalc_cnt_q <= recalc_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= sff_pkg::DIM_W'(sff_pkg::RESET_WIDTH);
			h_q    <= sff_pkg::DIM_W'(sff_pkg::RESET_HEIGHT);
			wh_q   <= LW'(sff_pkg::RESET_AREA);
			lead_q <= LW'(sff_pkg::RESET_LEAD);
		end else begin
			w_q    <= sff_pkg::clamp_dim(width_raw_q, sff_pkg::MAX_WIDTH);
			h_q    <= sff_pkg::clamp_dim(height_raw_q, sff_pkg::MAX_HEIGHT);
			wh_q   <= LW'(w_q) * LW'(h_q);
			lead_q <= LW'({w_q, 1'b0}) + LW'(3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			lin_in_q  <= '0;
			lin_out_q <= '0;
		end else if (recalc_cnt_q != 2'd0) begin
			lin_in_q  <= LW'(in_row_q) * LW'(w_q) + LW'(in_col_q);
			lin_out_q <= LW'(out_row_q) * LW'(w_q) + LW'(out_col_q);
		end else if (accept) begin
			if (done) begin
				in_row_q  <= r_in_row;
				in_col_q  <= r_in_col;
				out_row_q <= r_out_row;
				out_col_q <= r_out_col;
				lin_in_q  <= r_lin_in;
				lin_out_q <= r_lin_out;
			end else begin
				in_row_q <= new_in_row;
				in_col_q <= new_in_col;
				lin_in_q <= new_lin_in;
				if (emit) begin
					out_row_q <= new_out_row;
					out_col_q <= new_out_col;
					lin_out_q <= new_lin_out;
				end else begin
					out_row_q <= r_out_row;
					out_col_q <= r_out_col;
					lin_out_q <= r_lin_out;
				end
			end
		end
	end

	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		write_enable |=> !in_ready)
		else $error("item accepted while derived frame values were stale");

	a_done_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && done) |-> !push)
		else $error("item pushed after the frame was complete");

endmodule

// File: hw/rtl/sff_queue.sv
module sff_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sff_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output sff_pkg::cmd_t head_cmd
);

	sff_pkg::cmd_t                mem_q [sff_pkg::QUEUE_DEPTH];
	logic [sff_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [sff_pkg::QCNT_W-1:0]   cnt_q;

	assign full       = cnt_q == sff_pkg::QCNT_W'(sff_pkg::QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == sff_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == sff_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("command queue underflow");

endmodule

// File: hw/rtl/sff_back.sv
module sff_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  sff_pkg::cmd_t               q_cmd,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sff_pkg::FEAT_W-1:0]  feature_scaled,
	output logic                        is_border,
	output logic                        last_of_frame
);

	localparam int PW = sff_pkg::PIX_W;
	localparam int FW = sff_pkg::FEAT_W;

	logic          valid_s1, valid_s2, valid_s3;
	sff_pkg::cmd_t cmd_s1, cmd_s2;
	logic          emit_s3, border_s3, last_s3;

	logic [sff_pkg::LINE_W-1:0] rdata, line_rd, wdata;
	logic [sff_pkg::LINE_W-1:0] fwd_data_q;
	logic                       fwd_hit_q;
	logic [PW-1:0]              col_px [5];
	logic [PW-1:0]              win_q [5][5];

	logic [PW+2:0] sum5a_s3, sum5b_s3;
	logic [PW+1:0] sum25_s3, sum50_s3;
	logic [PW-1:0] ctr_s3;
	logic [FW-1:0] feat;

	sff_pkg::res_t            ofifo_q [sff_pkg::OUT_DEPTH];
	logic [sff_pkg::OPTR_W-1:0] owr_q, ord_q;
	logic [sff_pkg::OCNT_W-1:0] ocnt_q;
	logic [sff_pkg::OCNT_W+1:0] committed;
	logic                       opush, opop;

	always_comb begin
		committed = (sff_pkg::OCNT_W+2)'(ocnt_q) + (sff_pkg::OCNT_W+2)'(valid_s1)
			+ (sff_pkg::OCNT_W+2)'(valid_s2) + (sff_pkg::OCNT_W+2)'(valid_s3);
		q_pop = q_valid && (committed < (sff_pkg::OCNT_W+2)'(sff_pkg::OUT_DEPTH));
	end

	sff_ram #(
		.WIDTH(sff_pkg::LINE_W),
		.DEPTH(sff_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (valid_s1),
		.waddr(cmd_s1.col),
		.wdata(wdata),
		.re   (q_pop),
		.raddr(q_cmd.col),
		.rdata(rdata)
	);

	always_comb begin
		line_rd = fwd_hit_q ? fwd_data_q : rdata;
		for (int r = 0; r < sff_pkg::LANES; r++) begin
			col_px[r] = line_rd[r*PW +: PW];
		end
		col_px[sff_pkg::LANES] = cmd_s1.value;
		for (int r = 0; r < sff_pkg::LANES; r++) begin
			wdata[r*PW +: PW] = col_px[r+1];
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wdata;
		cmd_s1     <= q_cmd;
		cmd_s2     <= cmd_s1;
		emit_s3    <= cmd_s2.emit;
		border_s3  <= cmd_s2.border;
		last_s3    <= cmd_s2.last;
		sum5a_s3   <= (PW+3)'(win_q[0][1]) + (PW+3)'(win_q[0][2]) + (PW+3)'(win_q[0][3])
			+ (PW+3)'(win_q[1][0]) + (PW+3)'(win_q[1][4]);
		sum5b_s3   <= (PW+3)'(win_q[2][0]) + (PW+3)'(win_q[2][4]) + (PW+3)'(win_q[3][0])
			+ (PW+3)'(win_q[3][4]) + (PW+3)'(win_q[4][1]) + (PW+3)'(win_q[4][2])
			+ (PW+3)'(win_q[4][3]);
		sum25_s3   <= (PW+2)'(win_q[1][1]) + (PW+2)'(win_q[1][3])
			+ (PW+2)'(win_q[3][1]) + (PW+2)'(win_q[3][3]);
		sum50_s3   <= (PW+2)'(win_q[1][2]) + (PW+2)'(win_q[3][2])
			+ (PW+2)'(win_q[2][1]) + (PW+2)'(win_q[2][3]);
		ctr_s3     <= win_q[2][2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			fwd_hit_q <= 1'b0;
			for (int r = 0; r < 5; r++) begin
				for (int x = 0; x < 5; x++) begin
					win_q[r][x] <= '0;
				end
			end
		end else begin
			valid_s1  <= q_pop;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			fwd_hit_q <= q_pop && valid_s1 && (q_cmd.col == cmd_s1.col);
			if (valid_s1) begin
				for (int r = 0; r < 5; r++) begin
					for (int x = 0; x < 4; x++) begin
						win_q[r][x] <= win_q[r][x+1];
					end
					win_q[r][4] <= col_px[r];
				end
			end
		end
	end

	always_comb begin
		if (border_s3) begin
			feat = FW'(ctr_s3) * FW'(sff_pkg::K_SCALE);
		end else begin
			feat = FW'(sff_pkg::K_EDGE) * (FW'(sum5a_s3) + FW'(sum5b_s3))
				+ FW'(sff_pkg::K_NEAR) * FW'(sum25_s3)
				+ FW'(sff_pkg::K_SIDE) * FW'(sum50_s3)
				+ FW'(sff_pkg::K_CENTER) * FW'(ctr_s3);
		end
	end

	assign opush = valid_s3 && emit_s3;
	assign opop  = out_valid && out_ready;

	assign out_valid      = ocnt_q != '0;
	assign feature_scaled = ofifo_q[ord_q].feat;
	assign is_border      = ofifo_q[ord_q].border;
	assign last_of_frame  = ofifo_q[ord_q].last;

	always_ff @(posedge clk) begin
		if (opush) begin
			ofifo_q[owr_q].feat   <= feat;
			ofifo_q[owr_q].border <= border_s3;
			ofifo_q[owr_q].last   <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (opush) begin
				owr_q <= (int'(owr_q) == sff_pkg::OUT_DEPTH - 1) ? '0 : owr_q + 1'b1;
			end
			if (opop) begin
				ord_q <= (int'(ord_q) == sff_pkg::OUT_DEPTH - 1) ? '0 : ord_q + 1'b1;
			end
			if (opush && !opop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (opop && !opush) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		opush |-> (ocnt_q != sff_pkg::OCNT_W'(sff_pkg::OUT_DEPTH) || opop))
		else $error("result pushed into a full output buffer");

	a_fwd_target: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_hit_q |-> valid_s1)
		else $error("line forward without an item in the shift stage");

	a_pop_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> valid_s1)
		else $error("popped command lost before the shift stage");

endmodule

// File: hw/rtl/smooth_5x5_feature_filter_top.sv
// Raster 5x5 smoothing filter. Pixels enter on the input channel (in_valid,
// in_ready) one item per clock while in_ready is high; each item is a pixel or
// a flush. Results leave on the output channel (out_valid, out_ready) in
// raster order, one for each pixel of the frame, and each carries the scaled
// feature, a border flag and an end-of-frame flag. The result for a pixel
// follows the item that arrives 2*W+2 items after it through the line buffer,
// window and adder stages. Flush items push the last two rows out. Throughput
// is one item per clock when not stalled, set by the read-modify-write of one
// column of the line memory and the position counters of the input stage. The
// image width and height must be written on the register port while the block
// is idle; the block does not enforce it. Each write holds in_ready low while
// the frame area and linear positions are recomputed with the new dimensions.
// Reset clears the positions and the 5x5 window and loads a 640 by 480 frame.
// When the receiver stalls, results collect in an eight-entry output buffer and
// a four-entry command queue; once both fill, in_ready goes low until the
// receiver takes items again. No item is lost or repeated.
module smooth_5x5_feature_filter_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        write_enable,
	input  logic [0:0]                  reg_index,
	input  logic [sff_pkg::DIM_W-1:0]   write_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        operation,
	input  logic [sff_pkg::PIX_W-1:0]   pixel,
	input  logic                        first_of_frame,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sff_pkg::FEAT_W-1:0]  feature_scaled,
	output logic                        is_border,
	output logic                        last_of_frame
);

	logic          q_full, push, q_pop, q_valid;
	sff_pkg::cmd_t push_cmd, q_cmd;

	sff_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.write_enable  (write_enable),
		.reg_index     (reg_index),
		.write_data    (write_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.pixel         (pixel),
		.first_of_frame(first_of_frame),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	sff_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_cmd  (q_cmd)
	);

	sff_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.feature_scaled(feature_scaled),
		.is_border     (is_border),
		.last_of_frame (last_of_frame)
	);

endmodule

// File: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sff_pkg::*;

	localparam int TAPS = 2 * BORDER + 1;
	localparam int CENTER_TAP = BORDER * TAPS + BORDER;
	localparam int MAX_GAP = 17;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_ITEMS = 750;
	localparam int PARTIAL_ITEMS = 160;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_FIXED
	} check_t;

	typedef struct {
		op_t              op;
		logic [PIX_W-1:0] pix;
		logic             sof;
		int               reps;
		check_t           chk;
		res_t             res;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                write_enable;
	logic [0:0]          reg_index;
	logic [DIM_W-1:0]    write_data;
	logic                in_valid;
	logic                in_ready;
	logic                operation;
	logic [PIX_W-1:0]    pixel;
	logic                first_of_frame;
	logic                out_valid;
	logic                out_ready;
	logic [FEAT_W-1:0]   feature_scaled;
	logic                is_border;
	logic                last_of_frame;

	logic [PIX_W-1:0] line_mem [LANES * MAX_WIDTH];
	logic [PIX_W-1:0] win [TAPS * TAPS];
	int rx_row, rx_col, tx_row, tx_col;
	logic [DIM_W-1:0] cfg_width = DIM_W'(RESET_WIDTH);
	logic [DIM_W-1:0] cfg_height = DIM_W'(RESET_HEIGHT);
	int coeff [TAPS * TAPS] = '{
		0,      K_EDGE, K_EDGE,   K_EDGE, 0,
		K_EDGE, K_NEAR, K_SIDE,   K_NEAR, K_EDGE,
		K_EDGE, K_SIDE, K_CENTER, K_SIDE, K_EDGE,
		K_EDGE, K_NEAR, K_SIDE,   K_NEAR, K_EDGE,
		0,      K_EDGE, K_EDGE,   K_EDGE, 0
	};

	res_t pending_features [$];
	int fail_count = 0;
	int counted = 0;
	int snd_gap_max = MAX_GAP;
	int rcv_gap_max = MAX_GAP;

	// A 5x5 frame of full-scale pixels, the items past its end, and a second frame
	// that is restarted while its results are still due.
	stim_row_t directed_items [14] = '{
		'{OP_PIXEL, 8'd255, 1'b1, 1,  CHK_NONE,  '{18'd0, 1'b0, 1'b0}},
		'{OP_PIXEL, 8'd255, 1'b0, 11, CHK_NONE,  '{18'd0, 1'b0, 1'b0}},
		'{OP_PIXEL, 8'd255, 1'b0, 12, CHK_FIXED, '{18'd255000, 1'b1, 1'b0}},
		'{OP_PIXEL, 8'd255, 1'b0, 1,  CHK_FIXED, '{18'd255000, 1'b0, 1'b0}},
		'{OP_FLUSH, 8'd0,   1'b1, 1,  CHK_FIXED, '{18'd255000, 1'b1, 1'b0}},
		'{OP_FLUSH, 8'd85,  1'b0, 10, CHK_FIXED, '{18'd255000, 1'b1, 1'b0}},
		'{OP_FLUSH, 8'd170, 1'b1, 1,  CHK_FIXED, '{18'd255000, 1'b1, 1'b1}},
		'{OP_PIXEL, 8'd7,   1'b0, 1,  CHK_NONE,  '{18'd0, 1'b0, 1'b0}},
		'{OP_FLUSH, 8'd255, 1'b0, 1,  CHK_NONE,  '{18'd0, 1'b0, 1'b0}},
		'{OP_PIXEL, 8'd170, 1'b1, 1,  CHK_NONE,  '{18'd0, 1'b0, 1'b0}},
		'{OP_PIXEL, 8'd85,  1'b0, 11, CHK_NONE,  '{18'd0, 1'b0, 1'b0}},
		'{OP_PIXEL, 8'd0,   1'b0, 1,  CHK_FIXED, '{18'd170000, 1'b1, 1'b0}},
		'{OP_PIXEL, 8'd85,  1'b0, 1,  CHK_FIXED, '{18'd85000, 1'b1, 1'b0}},
		'{OP_PIXEL, 8'd255, 1'b1, 1,  CHK_NONE,  '{18'd0, 1'b0, 1'b0}}
	};

	smooth_5x5_feature_filter_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int dim_clamp(input logic [DIM_W-1:0] raw, input int top);
		int v;
		v = int'(raw);
		if (v < MIN_DIM) v = MIN_DIM;
		if (v > top) v = top;
		return v;
	endfunction

	function automatic bit filter_step(input op_t op, input logic [PIX_W-1:0] pix,
			input logic sof, output res_t r);
		int w, h, col, lin_in, lin_out, acc;
		logic [PIX_W-1:0] column [TAPS];
		bit drain, on_border;
		w = dim_clamp(cfg_width, MAX_WIDTH);
		h = dim_clamp(cfg_height, MAX_HEIGHT);
		drain = (op == OP_FLUSH);
		r = '0;
		if (!drain && sof) begin
			rx_row = 0;
			rx_col = 0;
			tx_row = 0;
			tx_col = 0;
		end
		if (tx_row >= h) return 1'b0;
		if (!drain && rx_row * w + rx_col >= w * h) drain = 1'b1;
		col = (rx_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : rx_col;
		for (int k = 0; k < LANES; k++) column[k] = line_mem[k * MAX_WIDTH + col];
		column[LANES] = drain ? '0 : pix;
		for (int k = 0; k < LANES; k++) line_mem[k * MAX_WIDTH + col] = column[k + 1];
		for (int k = 0; k < TAPS; k++) begin
			for (int x = 0; x < TAPS - 1; x++) win[k * TAPS + x] = win[k * TAPS + x + 1];
			win[k * TAPS + TAPS - 1] = column[k];
		end
		if (rx_col + 1 >= w) begin
			rx_col = 0;
			if (rx_row < int'(ROW_SAT)) rx_row++;
		end else begin
			rx_col++;
		end
		lin_in = rx_row * w + rx_col;
		lin_out = tx_row * w + tx_col;
		if (lin_in < lin_out + 2 * w + 3) return 1'b0;
		on_border = tx_row < BORDER || tx_row + BORDER >= h ||
			tx_col < BORDER || tx_col + BORDER >= w;
		if (on_border) begin
			acc = int'(win[CENTER_TAP]) * K_SCALE;
		end else begin
			acc = 0;
			for (int k = 0; k < TAPS * TAPS; k++) acc += coeff[k] * int'(win[k]);
		end
		r.feat = acc[FEAT_W-1:0];
		r.border = on_border;
		r.last = (tx_row + 1 == h) && (tx_col + 1 == w);
		if (tx_col + 1 >= w) begin
			tx_col = 0;
			tx_row++;
		end else begin
			tx_col++;
		end
		return 1'b1;
	endfunction

	task automatic set_pace();
		snd_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
		rcv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
	endtask

	task automatic send_item(input op_t op, input logic [PIX_W-1:0] pix, input logic sof,
			input check_t chk, input res_t fixed_res);
		int gap;
		bit got;
		res_t r;
		gap = $urandom_range(0, snd_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pixel <= pix;
		first_of_frame <= sof;
		do @(posedge clk); while (in_ready !== 1'b1);
		got = filter_step(op, pix, sof, r);
		if (chk == CHK_MODEL && got) pending_features.push_back(r);
		else if (chk == CHK_FIXED) pending_features.push_back(fixed_res);
	endtask

	task automatic drain_wait();
		in_valid <= 1'b0;
		while (pending_features.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [DIM_W-1:0] val);
		write_enable <= 1'b1;
		reg_index <= idx;
		write_data <= val;
		@(posedge clk);
		if (idx == REG_IMAGE_WIDTH) cfg_width = val;
		else cfg_height = val;
		write_enable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic feed_frame(input int first, input int stop, input bit noisy);
		for (int p = first; p < stop; p++) begin
			if (noisy && p != 0 && $urandom_range(0, 99) == 0) begin
				send_item(OP_FLUSH, 8'($urandom), 1'($urandom), CHK_MODEL, '0);
			end else begin
				send_item(OP_PIXEL, 8'($urandom), p == 0, CHK_MODEL, '0);
			end
			if (noisy && $urandom_range(0, 299) == 0) drain_wait();
			counted++;
		end
	endtask

	task automatic feed_drain(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) send_item(OP_PIXEL, 8'($urandom), 1'b0, CHK_MODEL, '0);
			else send_item(OP_FLUSH, 8'($urandom), 1'($urandom), CHK_MODEL, '0);
			counted++;
		end
	endtask

	initial begin : result_check
		int stall;
		res_t want;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, rcv_gap_max);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (pending_features.size() == 0) begin
				$error("unexpected result: feature_scaled %0d, is_border %0b, last_of_frame %0b",
					feature_scaled, is_border, last_of_frame);
				fail_count++;
			end else begin
				want = pending_features.pop_front();
				if (feature_scaled !== want.feat) begin
					$error("feature_scaled: expected %0d, got %0d", want.feat, feature_scaled);
					fail_count++;
				end
				if (is_border !== want.border) begin
					$error("is_border: expected %0b, got %0b", want.border, is_border);
					fail_count++;
				end
				if (last_of_frame !== want.last) begin
					$error("last_of_frame: expected %0b, got %0b", want.last, last_of_frame);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#(64'd100_000_000);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int n, w, h;
		logic [DIM_W-1:0] wr, hr;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_PIXEL;
		pixel = '0;
		first_of_frame = 1'b0;
		write_enable = 1'b0;
		reg_index = REG_IMAGE_WIDTH;
		write_data = '0;
		foreach (line_mem[i]) line_mem[i] = '0;
		foreach (win[i]) win[i] = '0;
		rx_row = 0;
		rx_col = 0;
		tx_row = 0;
		tx_col = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		set_pace();
		write_reg(REG_IMAGE_WIDTH, '0);
		write_reg(REG_IMAGE_HEIGHT, DIM_W'(4));
		foreach (directed_items[i]) begin
			for (n = 0; n < directed_items[i].reps; n++) begin
				send_item(directed_items[i].op, directed_items[i].pix, directed_items[i].sof,
					directed_items[i].chk, directed_items[i].res);
			end
		end

		// The start of the widest frame, then the start of the tallest frame.
		drain_wait();
		write_reg(REG_IMAGE_WIDTH, '1);
		write_reg(REG_IMAGE_HEIGHT, '0);
		set_pace();
		feed_frame(0, PARTIAL_ITEMS, 1'b1);
		drain_wait();
		write_reg(REG_IMAGE_WIDTH, DIM_W'(MIN_DIM));
		write_reg(REG_IMAGE_HEIGHT, DIM_W'(1500));
		set_pace();
		feed_frame(0, PARTIAL_ITEMS, 1'b1);

		// The frame shrinks while it is being received.
		drain_wait();
		write_reg(REG_IMAGE_WIDTH, DIM_W'(8));
		write_reg(REG_IMAGE_HEIGHT, DIM_W'(9));
		set_pace();
		feed_frame(0, 48, 1'b0);
		drain_wait();
		write_reg(REG_IMAGE_WIDTH, DIM_W'(6));
		write_reg(REG_IMAGE_HEIGHT, DIM_W'(7));
		feed_frame(48, 66, 1'b0);
		feed_drain(18);

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			drain_wait();
			wr = ($urandom_range(0, 5) == 0) ? DIM_W'($urandom_range(0, 4)) :
				DIM_W'($urandom_range(5, 12));
			hr = ($urandom_range(0, 5) == 0) ? DIM_W'($urandom_range(0, 4)) :
				DIM_W'($urandom_range(5, 8));
			write_reg(REG_IMAGE_WIDTH, wr);
			write_reg(REG_IMAGE_HEIGHT, hr);
			set_pace();
			w = dim_clamp(wr, MAX_WIDTH);
			h = dim_clamp(hr, MAX_HEIGHT);
			if ($urandom_range(0, 7) == 0) begin
				feed_frame(0, $urandom_range(1, w * h - 1), 1'b1);
			end else begin
				feed_frame(0, w * h, 1'b1);
				feed_drain(2 * w + 2);
				repeat ($urandom_range(0, 2)) begin
					send_item(OP_FLUSH, 8'($urandom), 1'($urandom), CHK_MODEL, '0);
				end
			end
		end

		in_valid <= 1'b0;
		for (n = 0; n < 5000 && pending_features.size() != 0; n++) @(posedge clk);
		if (pending_features.size() != 0) begin
			$error("%0d expected results never arrived", pending_features.size());
			fail_count++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
